>>> design/c3t_pkg.sv
// c3t_pkg: types and constants shared by the conv3x3_threshold_stream block.
// Holds field widths, the register map, the config bundle and the result word.
// No dependencies.
package c3t_pkg;

	localparam int KERNEL_SIZE = 3;
	localparam int COEF_W      = 8;
	localparam int FILT_W      = 16;
	localparam int ROW_W       = 12;
	localparam int COL_OUT_W   = 10;
	localparam int MAXV_W      = 15;
	localparam int THR_W       = 16;
	localparam int IMG_W_W     = 11;
	localparam int IMG_H_W     = 12;
	localparam int ROWREG_W    = 24;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = 3;
	localparam int FIFO_CNT_W  = 4;

	localparam logic [MAXV_W-1:0]   RESET_MAX      = 15'd255;
	localparam logic [ROWREG_W-1:0] COEF_TOP_RESET = 24'hF0F0F0;
	localparam logic [ROWREG_W-1:0] COEF_MID_RESET = 24'h000000;
	localparam logic [ROWREG_W-1:0] COEF_BOT_RESET = 24'h101010;
	localparam logic [IMG_W_W-1:0]  WIDTH_RESET    = 11'd640;
	localparam logic [IMG_H_W-1:0]  HEIGHT_RESET   = 12'd480;

	typedef enum logic [2:0] {
		REG_COEF_TOP = 3'd0,
		REG_COEF_MID = 3'd1,
		REG_COEF_BOT = 3'd2,
		REG_THRESH   = 3'd3,
		REG_WIDTH    = 3'd4,
		REG_HEIGHT   = 3'd5
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic [ROWREG_W-1:0]     coef_top;
		logic [ROWREG_W-1:0]     coef_mid;
		logic [ROWREG_W-1:0]     coef_bot;
		logic signed [THR_W-1:0] threshold;
		logic [IMG_W_W-1:0]      image_width;
		logic [IMG_H_W-1:0]      image_height;
	} cfg_t;

	typedef struct packed {
		logic                 emit;
		logic                 last;
		logic                 pre_rst;
		logic                 post_rst;
		logic [ROW_W-1:0]     centre_row;
		logic [COL_OUT_W-1:0] centre_col;
	} tag_t;

	typedef struct packed {
		logic signed [FILT_W-1:0] filtered;
		logic [ROW_W-1:0]         centre_row;
		logic [COL_OUT_W-1:0]     centre_col;
		logic [MAXV_W-1:0]        running_max;
		logic                     last;
	} res_t;

endpackage

>>> design/c3t_pixel_if.sv
// c3t_pixel_if: valid/ready channel that carries one pixel word.
// Standalone; width set by PIXEL_BITS.
interface c3t_pixel_if #(parameter int PIXEL_BITS = 8);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

>>> design/c3t_result_if.sv
// c3t_result_if: valid/ready channel that carries one filtered result word.
// Field widths come from c3t_pkg.
interface c3t_result_if;
	logic                          valid;
	logic                          ready;
	logic signed [c3t_pkg::FILT_W-1:0] filtered;
	logic [c3t_pkg::ROW_W-1:0]     centre_row;
	logic [c3t_pkg::COL_OUT_W-1:0] centre_col;
	logic [c3t_pkg::MAXV_W-1:0]    running_max;
	logic                          last;

	modport source (output valid, output filtered, output centre_row, output centre_col,
		output running_max, output last, input ready);
	modport sink   (input valid, input filtered, input centre_row, input centre_col,
		input running_max, input last, output ready);
endinterface

>>> design/c3t_apb_regs.sv
// c3t_apb_regs: APB-style register file for kernel, threshold and geometry.
// Depends on c3t_pkg for the register map and the cfg_t bundle.
module c3t_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [c3t_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [c3t_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [c3t_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output c3t_pkg::cfg_t                    cfg
);
	import c3t_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_top     <= COEF_TOP_RESET;
			cfg_q.coef_mid     <= COEF_MID_RESET;
			cfg_q.coef_bot     <= COEF_BOT_RESET;
			cfg_q.threshold    <= '0;
			cfg_q.image_width  <= WIDTH_RESET;
			cfg_q.image_height <= HEIGHT_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_COEF_TOP: cfg_q.coef_top     <= pwdata[ROWREG_W-1:0];
				REG_COEF_MID: cfg_q.coef_mid     <= pwdata[ROWREG_W-1:0];
				REG_COEF_BOT: cfg_q.coef_bot     <= pwdata[ROWREG_W-1:0];
				REG_THRESH:   cfg_q.threshold    <= $signed(pwdata[THR_W-1:0]);
				REG_WIDTH:    cfg_q.image_width  <= pwdata[IMG_W_W-1:0];
				REG_HEIGHT:   cfg_q.image_height <= pwdata[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COEF_TOP: prdata = APB_DATA_W'(cfg_q.coef_top);
			REG_COEF_MID: prdata = APB_DATA_W'(cfg_q.coef_mid);
			REG_COEF_BOT: prdata = APB_DATA_W'(cfg_q.coef_bot);
			REG_THRESH:   prdata = APB_DATA_W'(unsigned'(cfg_q.threshold));
			REG_WIDTH:    prdata = APB_DATA_W'(cfg_q.image_width);
			REG_HEIGHT:   prdata = APB_DATA_W'(cfg_q.image_height);
			default:      prdata = '0;
		endcase
	end

endmodule

>>> design/c3t_line_store.sv
// c3t_line_store: the two previous image rows, packed one column per word.
// Read-modify-write: read a column into a register, then write it back from that
// register shifted by one row with the new pixel. Uses no package items.
module c3t_line_store #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [PIXEL_BITS-1:0]        wr_pix,
	output logic [PIXEL_BITS-1:0]        top,
	output logic [PIXEL_BITS-1:0]        mid
);
	logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= {rd_q[PIXEL_BITS-1:0], wr_pix};
		end
	end

	assign top = rd_q[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid = rd_q[PIXEL_BITS-1:0];

endmodule

>>> design/c3t_cell.sv
// c3t_cell: one window column of three pixels and its multiply-add.
// Hands its column to the next older cell on each shift; registers the partial
// sum every cycle. Depends on c3t_pkg for coef_t and KERNEL_SIZE.
module c3t_cell #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  shift,
	input  logic [c3t_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]       col_in,
	input  c3t_pkg::coef_t [c3t_pkg::KERNEL_SIZE-1:0]             coef,
	output logic [c3t_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]       col_out,
	output logic signed [PIXEL_BITS+10:0]                         psum_s3
);
	import c3t_pkg::*;

	localparam int PROD_W = PIXEL_BITS + 9;
	localparam int PSUM_W = PIXEL_BITS + 11;

	logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0] pix_q;
	logic signed [PROD_W-1:0]               prod [KERNEL_SIZE];
	logic signed [PSUM_W-1:0]               psum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= col_in;
		end
	end

	always_comb begin
		psum = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			prod[i] = $signed({1'b0, pix_q[i]}) * $signed(coef[i]);
			psum    = psum + PSUM_W'(prod[i]);
		end
	end

	always_ff @(posedge clk) begin
		psum_s3 <= psum;
	end

	assign col_out = pix_q;

endmodule

>>> design/c3t_out_fifo.sv
// c3t_out_fifo: result queue between the pipeline and the output channel.
// Depends on c3t_pkg for res_t and the queue depth; drives c3t_result_if.
module c3t_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  c3t_pkg::res_t                 push_data,
	output logic [c3t_pkg::FIFO_CNT_W-1:0] count,
	c3t_result_if.source                  res
);
	import c3t_pkg::*;

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	res_t                  head;

	assign pop = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head            = mem_q[rd_ptr_q];
	assign count           = cnt_q;
	assign res.valid       = cnt_q != '0;
	assign res.filtered    = head.filtered;
	assign res.centre_row  = head.centre_row;
	assign res.centre_col  = head.centre_col;
	assign res.running_max = head.running_max;
	assign res.last        = head.last;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_PTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[FIFO_PTR_W-1:0])
		else $error("queue pointers disagree with count");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(cnt_q))
		else $error("count moved on simultaneous push and pop");
`endif

endmodule

>>> design/conv3x3_threshold_stream.sv
// conv3x3_threshold_stream: 3x3 convolution with rectifying threshold on a
// raster-order gray pixel stream. Depends on c3t_pkg, c3t_pixel_if,
// c3t_result_if, c3t_apb_regs, c3t_line_store, c3t_cell and c3t_out_fifo.
//
// The block takes one pixel per clock while input ready is high and gives one
// result per interior pixel. The rate is set by the line store, a single
// memory of MAX_WIDTH words, each holding both previous rows of one column,
// read and written back once per pixel. The 3x3 window is a chain of three
// column cells; each cell multiplies its column by the matching kernel column,
// and the three partial sums are added, thresholded, divided by 16 with
// truncation toward zero, saturated and passed through the running-maximum
// stage into an 8-word result queue. The input stays ready while the queue and
// the five pipeline stages together hold fewer than 8 words, so a stalled
// output is absorbed for several pixels before input ready drops. The line
// store has no clearing pass and needs none for any fixed geometry. Reprogram
// registers only while the block is idle.
module conv3x3_threshold_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	c3t_pixel_if.sink                        pix,
	c3t_result_if.source                     res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [c3t_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [c3t_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [c3t_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import c3t_pkg::*;

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int PSUM_W = PIXEL_BITS + 11;
	localparam int SUM_W  = PIXEL_BITS + 13;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

	cfg_t cfg;

	c3t_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// geometry in use
	logic [CW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;

	always_comb begin
		if (cfg.image_width < IMG_W_W'(3)) begin
			eff_w = CW'(3);
		end else if (int'(cfg.image_width) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(cfg.image_width);
		end
		eff_h = (cfg.image_height < IMG_H_W'(3)) ? ROW_W'(3) : cfg.image_height;
	end

	// raster position
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    c, c_inc, col_nxt;
	logic [ROW_W-1:0] r0, r, row_nxt;
	logic             wrap_in, pre_rst, wrap_out, img_end;
	logic             acc;
	tag_t             tag_in;

	assign acc = pix.valid && pix.ready;

	always_comb begin
		wrap_in  = col_q >= eff_w;
		c        = wrap_in ? '0 : col_q;
		r0       = wrap_in ? row_q + ROW_W'(1) : row_q;
		pre_rst  = r0 >= eff_h;
		r        = pre_rst ? '0 : r0;
		c_inc    = c + CW'(1);
		wrap_out = c_inc >= eff_w;
		img_end  = ({1'b0, r} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
		col_nxt  = wrap_out ? '0 : c_inc;
		if (wrap_out) begin
			row_nxt = img_end ? '0 : r + ROW_W'(1);
		end else begin
			row_nxt = r;
		end
		tag_in.emit       = (r >= ROW_W'(2)) && (c >= CW'(2));
		tag_in.last       = (r == eff_h - ROW_W'(1)) && (c == eff_w - CW'(1));
		tag_in.pre_rst    = pre_rst;
		tag_in.post_rst   = wrap_out && img_end;
		tag_in.centre_row = r - ROW_W'(1);
		tag_in.centre_col = COL_OUT_W'(c - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// pipeline valids and tags
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [AW-1:0]         addr_s1;
	logic [PIXEL_BITS-1:0] px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= tag_in;
		addr_s1 <= c[AW-1:0];
		px_s1   <= pix.pixel;
		tag_s2  <= tag_s1;
		tag_s3  <= tag_s2;
		tag_s4  <= tag_s3;
		tag_s5  <= tag_s4;
	end

	// line store
	logic [PIXEL_BITS-1:0] ls_top, ls_mid;

	c3t_line_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_line_store (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (c[AW-1:0]),
		.wr_en   (v_s1),
		.wr_addr (addr_s1),
		.wr_pix  (px_s1),
		.top     (ls_top),
		.mid     (ls_mid)
	);

	// window: chain of column cells, cell KERNEL_SIZE-1 holds the newest column
	logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0]              new_col;
	logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIXEL_BITS-1:0] win_col;
	coef_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0]            coef_col;
	logic signed [PSUM_W-1:0]                            psum_s3 [KERNEL_SIZE];

	assign new_col = {px_s1, ls_mid, ls_top};

	always_comb begin
		for (int j = 0; j < KERNEL_SIZE; j++) begin
			coef_col[j][0] = coef_t'(cfg.coef_top[COEF_W*j +: COEF_W]);
			coef_col[j][1] = coef_t'(cfg.coef_mid[COEF_W*j +: COEF_W]);
			coef_col[j][2] = coef_t'(cfg.coef_bot[COEF_W*j +: COEF_W]);
		end
	end

	for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
		logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0] cin;
		if (j == KERNEL_SIZE - 1) begin : g_head
			assign cin = new_col;
		end else begin : g_link
			assign cin = win_col[j+1];
		end
		c3t_cell #(
			.PIXEL_BITS (PIXEL_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (v_s1),
			.col_in  (cin),
			.coef    (coef_col[j]),
			.col_out (win_col[j]),
			.psum_s3 (psum_s3[j])
		);
	end

	// full sum
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_s4;

	always_comb begin
		sum = '0;
		for (int j = 0; j < KERNEL_SIZE; j++) begin
			sum = sum + SUM_W'(psum_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= sum;
	end

	// threshold, truncate toward zero, saturate
	logic signed [SUM_W-1:0]  thr_ext, biased, quo;
	logic signed [FILT_W-1:0] val, val_s5;

	always_comb begin
		thr_ext = {{(SUM_W-THR_W-4){cfg.threshold[THR_W-1]}}, cfg.threshold, 4'b0000};
		biased  = sum_s4 + (sum_s4[SUM_W-1] ? SUM_W'(15) : SUM_W'(0));
		quo     = biased >>> 4;
		priority if (sum_s4 < thr_ext) begin
			val = '0;
		end else if (quo > SAT_HI) begin
			val = FILT_W'(SAT_HI);
		end else if (quo < SAT_LO) begin
			val = FILT_W'(SAT_LO);
		end else begin
			val = quo[FILT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		val_s5 <= val;
	end

	// running maximum
	logic [MAXV_W-1:0] max_q, max_base, max_new;
	res_t              push_data;
	logic              push;

	always_comb begin
		max_base = tag_s5.pre_rst ? RESET_MAX : max_q;
		if (tag_s5.emit && (val_s5 > $signed({1'b0, max_base}))) begin
			max_new = val_s5[MAXV_W-1:0];
		end else begin
			max_new = max_base;
		end
		push                  = v_s5 && tag_s5.emit;
		push_data.filtered    = val_s5;
		push_data.centre_row  = tag_s5.centre_row;
		push_data.centre_col  = tag_s5.centre_col;
		push_data.running_max = max_new;
		push_data.last        = tag_s5.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= RESET_MAX;
		end else if (v_s5) begin
			max_q <= tag_s5.post_rst ? RESET_MAX : max_new;
		end
	end

	// result queue and input credit
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [2:0]            inflight;

	c3t_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (fifo_cnt),
		.res       (res)
	);

	assign inflight  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign pix.ready = (5'(fifo_cnt) + 5'(inflight)) < 5'(FIFO_DEPTH);

`ifndef SYNTHESIS
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(fifo_cnt) + 5'(inflight)) <= 5'(FIFO_DEPTH))
		else $error("words in flight exceed queue space");
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && tag_s5.last |-> tag_s5.emit)
		else $error("last flag on a border pixel");
	a_max_floor: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_data.running_max >= RESET_MAX)
		else $error("running maximum below its floor");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for conv3x3_threshold_stream, built on c3t_pkg and the
// c3t_pixel_if / c3t_result_if channels; a directed table gives its expected words, a
// local window model those of two extreme-kernel frames, then of random frames.
module tb;
	import c3t_pkg::*;

	localparam int MAX_COLS    = 1024;
	localparam int SETTLE      = 16;
	localparam int STALL_MAX   = 12;
	localparam int HOLD_LEN    = 150;
	localparam int WATCHDOG    = 2000;
	localparam int RAND_ITEMS  = 560;
	localparam int CALM_FROM   = 480;
	localparam int PRESS_PHASE = 1;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam res_t NO_WORD = '0;

	typedef struct {
		bit          is_reg;
		logic [2:0]  idx;
		logic [31:0] val;
		logic [7:0]  pixel;
		bit          known;
		res_t        want;
	} dir_step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	c3t_pixel_if #(.PIXEL_BITS(8)) pix_bus ();
	c3t_result_if res_bus ();

	conv3x3_threshold_stream #(.MAX_WIDTH(MAX_COLS), .PIXEL_BITS(8)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_bus),
		.res(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cfg_t       regs;
	logic [7:0] row_up1 [MAX_COLS];
	logic [7:0] row_up2 [MAX_COLS];
	logic [7:0] win [3][3];
	int         col_pos;
	int         row_pos;
	int         max_val;
	res_t       due_results [$];
	int         mismatches;
	int         stuck_cycles;
	bit         dir_known;
	res_t       dir_want;
	bit         calm;
	bit         quiet;
	int         hold_asked;
	int         hold_served;
	int         hold_left;
	int         stall_left;

	dir_step_t dir_tab [0:21] = '{
		'{1'b1, REG_WIDTH,   32'd2,         8'h00, 1'b0, NO_WORD},
		'{1'b1, REG_HEIGHT,  32'd0,         8'h00, 1'b0, NO_WORD},
		'{1'b1, REG_SPARE_A, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_WORD},
		'{1'b1, REG_SPARE_B, 32'h0000_0005, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h5A, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hA5, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h3C, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b1, '{16'sd765, 12'd1, 10'd1, 15'd765, 1'b1}},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hFF, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hC3, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h0F, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'hF0, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b0, NO_WORD},
		'{1'b0, REG_SPARE_A, 32'd0, 8'h00, 1'b1, '{16'sd0, 12'd1, 10'd1, 15'd255, 1'b1}}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_window_model();
		regs = '{COEF_TOP_RESET, COEF_MID_RESET, COEF_BOT_RESET, 16'sd0,
			WIDTH_RESET, HEIGHT_RESET};
		for (int i = 0; i < MAX_COLS; i++) begin
			row_up1[i] = '0;
			row_up2[i] = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		max_val = int'(RESET_MAX);
	endfunction

	function automatic void note_reg(input logic [2:0] idx, input logic [31:0] v);
		case (idx)
		REG_COEF_TOP: regs.coef_top = v[ROWREG_W-1:0];
		REG_COEF_MID: regs.coef_mid = v[ROWREG_W-1:0];
		REG_COEF_BOT: regs.coef_bot = v[ROWREG_W-1:0];
		REG_THRESH:   regs.threshold = v[THR_W-1:0];
		REG_WIDTH:    regs.image_width = v[IMG_W_W-1:0];
		REG_HEIGHT:   regs.image_height = v[IMG_H_W-1:0];
		default: ;
		endcase
	endfunction

	function automatic int used_width();
		int w;
		w = int'(regs.image_width);
		if (w < 3) w = 3;
		if (w > MAX_COLS) w = MAX_COLS;
		return w;
	endfunction

	function automatic int used_height();
		return (regs.image_height < 3) ? 3 : int'(regs.image_height);
	endfunction

	function automatic int kernel_tap(input logic [ROWREG_W-1:0] rowreg, input int b);
		coef_t k;
		k = rowreg[COEF_W*b +: COEF_W];
		return k;
	endfunction

	function automatic bit filter_pixel(input logic [7:0] px, output res_t word);
		int w, h, c, r, sum, val;
		bit emit;
		logic [ROWREG_W-1:0] krow [3];
		w = used_width();
		h = used_height();
		word = '0;
		emit = 1'b0;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) begin
			row_pos = 0;
			max_val = int'(RESET_MAX);
		end
		c = col_pos;
		r = row_pos;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 2; j++)
				win[i][j] = win[i][j+1];
		win[0][2] = row_up2[c];
		win[1][2] = row_up1[c];
		win[2][2] = px;
		row_up2[c] = row_up1[c];
		row_up1[c] = px;
		if (r >= 2 && c >= 2) begin
			krow[0] = regs.coef_top;
			krow[1] = regs.coef_mid;
			krow[2] = regs.coef_bot;
			sum = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					sum += int'(win[i][j]) * kernel_tap(krow[i], j);
			val = (sum < int'(regs.threshold) * 16) ? 0 : sum / 16;
			if (val > 32767) val = 32767;
			if (val < -32768) val = -32768;
			if (val > max_val) max_val = val;
			word.filtered = FILT_W'(val);
			word.centre_row = ROW_W'(r - 1);
			word.centre_col = COL_OUT_W'(c - 1);
			word.running_max = MAXV_W'(max_val);
			word.last = (r == h - 1) && (c == w - 1);
			emit = 1'b1;
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) begin
				row_pos = 0;
				max_val = int'(RESET_MAX);
			end
		end
		return emit;
	endfunction

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_coefs();
		case ($urandom_range(0, 5))
		0: return 32'h0080_8080;
		1: return 32'h007F_7F7F;
		2: return 32'h0000_0000;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_threshold();
		int t;
		t = $urandom_range(0, 600) - 300;
		case ($urandom_range(0, 7))
		0: return 32'h0000_8000;
		1: return 32'h0000_7FFF;
		2: return $urandom;
		default: return 32'(t);
		endcase
	endfunction

	task automatic check_field(input string what, input logic signed [31:0] want,
		input logic signed [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, got %0d", what, want, seen);
			mismatches++;
		end
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		note_reg(idx, v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic push_pixel(input logic [7:0] p, input bit known, input res_t want);
		@(negedge clk);
		if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
			pix_bus.valid = 1'b0;
			repeat ($urandom_range(1, STALL_MAX)) @(negedge clk);
		end
		pix_bus.valid = 1'b1;
		pix_bus.pixel = p;
		dir_known = known;
		dir_want = want;
		do @(posedge clk); while (!pix_bus.ready);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		pix_bus.valid = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_bus.ready = 1'b0;
		end else if (calm || quiet) begin
			res_bus.ready = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_bus.ready = 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, STALL_MAX) - 1;
			res_bus.ready = 1'b0;
		end else begin
			res_bus.ready = 1'b1;
		end
	end

	always @(posedge clk) begin : word_check
		res_t want;
		res_t got;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			if (filter_pixel(pix_bus.pixel, want))
				due_results.push_back(dir_known ? dir_want : want);
		end
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = '{res_bus.filtered, res_bus.centre_row, res_bus.centre_col,
				res_bus.running_max, res_bus.last};
			if (due_results.size() == 0) begin
				$error("result word with none pending: filtered %0d row %0d col %0d",
					got.filtered, got.centre_row, got.centre_col);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("filtered", want.filtered, got.filtered);
				check_field("centre_row", want.centre_row, got.centre_row);
				check_field("centre_col", want.centre_col, got.centre_col);
				check_field("running_max", want.running_max, got.running_max);
				check_field("last", want.last, got.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles == WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int w, h, c, r, left, n, phase, rand_sent;
		logic [10:0] wv;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		res_bus.ready = 1'b0;
		dir_known = 1'b0;
		dir_want = '0;
		calm = 1'b0;
		quiet = 1'b0;
		hold_asked = 0;
		hold_served = 0;
		hold_left = 0;
		stall_left = 0;
		mismatches = 0;
		stuck_cycles = 0;
		reset_window_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg)
				reg_write(dir_tab[i].idx, dir_tab[i].val);
			else
				push_pixel(dir_tab[i].pixel, dir_tab[i].known, dir_tab[i].want);
		end

		// most negative kernel, lowest threshold; as wide as any later narrow
		// frame, so every line store column those frames touch holds pixels
		settle_idle();
		reg_write(REG_WIDTH, 32'd15);
		reg_write(REG_HEIGHT, 32'd3);
		reg_write(REG_COEF_TOP, 32'h0080_8080);
		reg_write(REG_COEF_MID, 32'h0080_8080);
		reg_write(REG_COEF_BOT, 32'h0080_8080);
		reg_write(REG_THRESH, 32'h0000_8000);
		repeat (15 * 3)
			push_pixel(($urandom_range(0, 7) != 0) ? 8'hFF : 8'($urandom), 1'b0, NO_WORD);

		// narrowest frame, most positive kernel
		settle_idle();
		reg_write(REG_WIDTH, 32'd1);
		reg_write(REG_HEIGHT, 32'd10);
		reg_write(REG_COEF_TOP, 32'h007F_7F7F);
		reg_write(REG_COEF_MID, 32'h007F_7F7F);
		reg_write(REG_COEF_BOT, 32'h007F_7F7F);
		reg_write(REG_THRESH, 32'd0);
		repeat (3 * 10)
			push_pixel(($urandom_range(0, 7) != 0) ? 8'hFF : 8'($urandom), 1'b0, NO_WORD);

		phase = 0;
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			settle_idle();
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) reg_write(REG_COEF_TOP, pick_coefs());
			if ($urandom_range(0, 1)) reg_write(REG_COEF_MID, pick_coefs());
			if ($urandom_range(0, 1)) reg_write(REG_COEF_BOT, pick_coefs());
			if ($urandom_range(0, 1)) reg_write(REG_THRESH, pick_threshold());
			if (phase == PRESS_PHASE) begin
				reg_write(REG_WIDTH, 32'd8);
				reg_write(REG_HEIGHT, 32'd6);
			end else if ($urandom_range(0, 1)) begin
				// clamp wide rows only from the top of an image, so they stay in row 0
				wv = (col_pos == 0 && row_pos == 0 && $urandom_range(0, 11) == 0)
					? 11'($urandom_range(1025, 2047)) : 11'($urandom_range(0, 14));
				reg_write(REG_WIDTH, {21'($urandom), wv});
				reg_write(REG_HEIGHT, {20'($urandom), 12'($urandom_range(0, 8))});
			end
			w = used_width();
			h = used_height();
			c = col_pos;
			r = row_pos;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) r = 0;
			left = (h - r) * w - c;
			if (phase == PRESS_PHASE) begin
				n = left + w * h;
				@(posedge clk);
				hold_asked++;
			end else if (w == MAX_COLS || $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 40);
			end else begin
				n = left + (($urandom_range(0, 2) == 0) ? w * h : 0);
			end
			if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
			for (int k = 0; k < n; k++) begin
				push_pixel(pick_pixel(), 1'b0, NO_WORD);
				rand_sent++;
				if (rand_sent >= CALM_FROM) calm = 1'b1;
			end
			phase++;
		end

		settle_idle();
		if (mismatches == 0 && due_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
